FILE: hdl/ttps_pkg.sv
`default_nettype none
package ttps_pkg;

	// table geometry
	localparam int ENTRIES      = 4096;
	localparam int SCORE_BITS   = 16;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam bit ENTRIES_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

	// word fields
	localparam int HASH_W     = 64;
	localparam int DEPTH_W    = 7;
	localparam int IN_SCORE_W = 16;
	localparam int KIND_W     = 2;
	localparam int PLY_W      = 7;
	localparam int MT_W       = 15;
	localparam int REQ_W      = 2;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 16;

	localparam int PAY_W   = DEPTH_W + SCORE_BITS + KIND_W;
	localparam int ENTRY_W = HASH_W + PAY_W;
	localparam int HCNT_W  = $clog2(HASH_W);

	// working width for score arithmetic: room for ply and sign
	localparam int WIDE_W = ((SCORE_BITS > IN_SCORE_W) ? SCORE_BITS : IN_SCORE_W) + 2;
	localparam longint SMAX_L = (longint'(1) << (SCORE_BITS - 1)) - 1;
	localparam logic signed [WIDE_W-1:0] SCORE_MAX = WIDE_W'(SMAX_L);
	localparam logic signed [WIDE_W-1:0] SCORE_MIN = WIDE_W'(-SMAX_L - 1);

	// config port
	localparam int  PADDR_W      = 3;
	localparam int  PDATA_W      = 32;
	localparam logic REG_MATE_THR = 1'b0;
	localparam logic [MT_W-1:0] MATE_THR_RST = MT_W'(30000);

	typedef enum logic [REQ_W-1:0] {
		REQ_PROBE = 2'd0,
		REQ_STORE = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [KIND_W-1:0] {
		BOUND_EXACT = 2'd0,
		BOUND_UPPER = 2'd1,
		BOUND_LOWER = 2'd2
	} bound_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MOD,
		ST_ISSUE,
		ST_EVAL,
		ST_WRITE,
		ST_CLR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic rd_en;
		logic eval_en;
		logic st_adj;
		logic wr_store;
		logic wr_clear;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic mod_last;
		logic clr_last;
		logic out_free;
	} stat_t;

	function automatic logic signed [WIDE_W-1:0] sat_score(
		input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		if (v > SCORE_MAX)
			r = SCORE_MAX;
		else if (v < SCORE_MIN)
			r = SCORE_MIN;
		else
			r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/transposition_table_probe_store.sv
// Sequence: IDLE accepts a request word; when ENTRIES is no power of two, MOD first
//   reduces the hash to a slot. ISSUE then starts a probe read, store adjust or clear;
//   EVAL (probe), WRITE (store) or CLR (every slot) follows, unknown requests skip
//   ahead, and FIN loads the result register once it is free. One request word in flight.
// Reset: arst_n clears control, then a clearing pass zeroes all ENTRIES slots, one a
//   cycle, before the first request word is accepted; config writes work.
`default_nettype none
module transposition_table_probe_store
	import ttps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	// request words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [63:0] position_hash, [70:64] search_depth, [86:71] entry_score,
	// [88:87] bound_kind, [104:89] window_low, [120:105] window_high,
	// [127:121] ply_from_root
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [REQ_W-1:0]      s_tuser,

	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [15:0] result_value
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [0] found
	output logic                  m_tuser,

	// config port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	cmd_t  cmd;
	stat_t stat;

	// mate score threshold, register 0; low address bits are ignored
	logic [MT_W-1:0] mate_thr_q;
	logic            reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_MATE_THR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_thr_q <= MATE_THR_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mate_thr_q <= pwdata[MT_W-1:0];
		end
	end

	assign prdata = (psel && reg_hit) ? PDATA_W'(mate_thr_q) : '0;

	// sequencer: init clear, request capture, slot reduction, probe/store/clear steps, result hand-off
	ttps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, score adjust, hit decision and the output register
	ttps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mate_thr  (mate_thr_q),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_found (m_tuser),
		.out_value (m_tdata)
	);

endmodule
`default_nettype wire

FILE: hdl/ttps_table.sv
`default_nettype none
module ttps_table
	import ttps_pkg::*;
(
	input  logic               clk,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data
);

	logic [ENTRY_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ttps_dp.sv
`default_nettype none
module ttps_dp
	import ttps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [MT_W-1:0]       mate_thr,
	input  logic [REQ_W-1:0]      in_user,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_found,
	output logic [OUT_DATA_W-1:0] out_value
);

	// captured request
	req_t                      req_q;
	logic [HASH_W-1:0]         hash_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic signed [IN_SCORE_W-1:0] score_q;
	logic [KIND_W-1:0]         kind_q;
	logic signed [IN_SCORE_W-1:0] alpha_q;
	logic signed [IN_SCORE_W-1:0] beta_q;
	logic [PLY_W-1:0]          ply_q;

	// slot reduction for a non power-of-two table
	logic [HASH_W-1:0] mod_sh_q;
	logic [IDX_W-1:0]  rem_q;
	logic [HCNT_W-1:0] mod_cnt_q;
	logic [IDX_W:0]    rem_2x;
	logic [IDX_W-1:0]  slot;

	logic [IDX_W-1:0] clr_idx_q;

	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_en;

	logic [HASH_W-1:0]         rd_key;
	logic [DEPTH_W-1:0]        rd_depth;
	logic signed [SCORE_BITS-1:0] rd_score;
	logic [KIND_W-1:0]         rd_kind;

	logic signed [WIDE_W-1:0] thr_w;
	logic signed [WIDE_W-1:0] ply_w;
	logic signed [WIDE_W-1:0] pr_s0, pr_s1, pr_s2;
	logic signed [WIDE_W-1:0] st_s0, st_s1;
	logic signed [SCORE_BITS-1:0] st_score_q;

	logic                     hit_q;
	logic [KIND_W-1:0]        pkind_q;
	logic signed [WIDE_W-1:0] sadj_q;

	logic signed [WIDE_W-1:0] alpha_w, beta_w;
	logic                     found;
	logic signed [WIDE_W-1:0] value;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [OUT_DATA_W-1:0] out_value_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_t'(in_user);
			hash_q  <= in_data[63:0];
			depth_q <= in_data[70:64];
			score_q <= in_data[86:71];
			kind_q  <= in_data[88:87];
			alpha_q <= in_data[104:89];
			beta_q  <= in_data[120:105];
			ply_q   <= in_data[127:121];
		end
	end

	// remainder one hash bit per cycle, msb first
	assign rem_2x = {rem_q, mod_sh_q[HASH_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_sh_q  <= in_data[63:0];
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			mod_sh_q  <= {mod_sh_q[HASH_W-2:0], 1'b0};
			mod_cnt_q <= mod_cnt_q + 1'b1;
			if (rem_2x >= (IDX_W + 1)'(ENTRIES))
				rem_q <= IDX_W'(rem_2x - (IDX_W + 1)'(ENTRIES));
			else
				rem_q <= IDX_W'(rem_2x);
		end
	end

	assign slot = ENTRIES_POW2 ? hash_q[IDX_W-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.wr_clear) begin
			if (stat.clr_last)
				clr_idx_q <= '0;
			else
				clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign wr_en   = cmd.wr_store | cmd.wr_clear;
	assign wr_addr = cmd.wr_clear ? clr_idx_q : slot;
	assign wr_data = cmd.wr_clear ? '0 : {hash_q, depth_q, st_score_q, kind_q};

	ttps_table u_table (
		.clk     (clk),
		.rd_en   (cmd.rd_en),
		.rd_addr (slot),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign {rd_key, rd_depth, rd_score, rd_kind} = rd_data;

	assign thr_w = WIDE_W'(mate_thr);
	assign ply_w = WIDE_W'(ply_q);

	// probe: mate score pulled toward zero, two checks in order
	assign pr_s0 = WIDE_W'(rd_score);
	assign pr_s1 = (pr_s0 < -thr_w) ? pr_s0 + ply_w : pr_s0;
	assign pr_s2 = (pr_s1 > thr_w) ? pr_s1 - ply_w : pr_s1;

	// store: mate score pushed away from zero
	assign st_s0 = WIDE_W'(score_q);
	always_comb begin
		if (st_s0 > thr_w)
			st_s1 = st_s0 + ply_w;
		else if (st_s0 < -thr_w)
			st_s1 = st_s0 - ply_w;
		else
			st_s1 = st_s0;
	end

	always_ff @(posedge clk) begin
		if (cmd.st_adj) begin
			st_score_q <= SCORE_BITS'(sat_score(st_s1));
		end
		if (cmd.eval_en) begin
			hit_q   <= (rd_key == hash_q) && (rd_depth >= depth_q);
			pkind_q <= rd_kind;
			sadj_q  <= sat_score(pr_s2);
		end
	end

	assign alpha_w = WIDE_W'(alpha_q);
	assign beta_w  = WIDE_W'(beta_q);

	always_comb begin
		found = 1'b0;
		value = '0;
		if (req_q == REQ_PROBE && hit_q) begin
			case (pkind_q)
				BOUND_EXACT: begin
					found = 1'b1;
					value = sadj_q;
				end
				BOUND_UPPER: begin
					if (sadj_q <= alpha_w) begin
						found = 1'b1;
						value = alpha_w;
					end
				end
				BOUND_LOWER: begin
					if (sadj_q >= beta_w) begin
						found = 1'b1;
						value = beta_w;
					end
				end
				default: begin
					found = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found_q <= found;
			out_value_q <= value[OUT_DATA_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_value = out_value_q;

	assign stat.req      = req_q;
	assign stat.mod_last = (mod_cnt_q == HCNT_W'(HASH_W - 1));
	assign stat.clr_last = (clr_idx_q == IDX_W'(ENTRIES - 1));
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

FILE: hdl/ttps_ctrl.sv
`default_nettype none
module ttps_ctrl
	import ttps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.wr_clear = 1'b1;
				if (stat.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ENTRIES_POW2 ? ST_ISSUE : ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				unique case (stat.req)
					REQ_PROBE: begin
						cmd.rd_en = 1'b1;
						state_d   = ST_EVAL;
					end
					REQ_STORE: begin
						cmd.st_adj = 1'b1;
						state_d    = ST_WRITE;
					end
					REQ_CLEAR: state_d = ST_CLR;
					REQ_NONE:  state_d = ST_FIN;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_EVAL: begin
				cmd.eval_en = 1'b1;
				state_d     = ST_FIN;
			end
			ST_WRITE: begin
				cmd.wr_store = 1'b1;
				state_d      = ST_FIN;
			end
			ST_CLR: begin
				cmd.wr_clear = 1'b1;
				if (stat.clr_last)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

endmodule
`default_nettype wire

FILE: sim/ttps_response_checker.sv
`timescale 1ns / 1ps
module ttps_response_checker
	import ttps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [REQ_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	input  logic                  pready,
	output logic [31:0]           fail_count,
	output logic [31:0]           pending
);

	localparam logic [PADDR_W-1:0] MATE_THR_ADDR = PADDR_W'(4 * REG_MATE_THR);

	// request word layout, top bits first
	typedef struct packed {
		logic [PLY_W-1:0]      ply;
		logic [IN_SCORE_W-1:0] beta;
		logic [IN_SCORE_W-1:0] alpha;
		logic [KIND_W-1:0]     kind;
		logic [IN_SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]    depth;
		logic [HASH_W-1:0]     hash;
	} request_t;

	typedef struct packed {
		logic                  found;
		logic [OUT_DATA_W-1:0] value;
	} response_t;

	logic [HASH_W-1:0]  key_tab   [ENTRIES];
	logic [DEPTH_W-1:0] depth_tab [ENTRIES];
	longint             score_tab [ENTRIES];
	logic [KIND_W-1:0]  kind_tab  [ENTRIES];
	longint             mate_thr;
	response_t          expected_q [$];
	int                 errors;

	function automatic longint clamp_score(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (SCORE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			key_tab[i]   = '0;
			depth_tab[i] = '0;
			score_tab[i] = 0;
			kind_tab[i]  = BOUND_EXACT;
		end
	endfunction

	// applies one request to the shadow table, returns the word it answers with
	function automatic response_t apply_request(input request_t w, input req_t req);
		response_t rsp;
		int        slot;
		longint    s;
		longint    ply;
		longint    value;
		logic      hit;
		rsp   = '0;
		hit   = 1'b0;
		value = 0;
		slot  = int'(w.hash % 64'(ENTRIES));
		ply   = longint'(w.ply);
		case (req)
			REQ_PROBE: begin
				if (key_tab[slot] == w.hash && depth_tab[slot] >= w.depth) begin
					s = score_tab[slot];
					// both checks in turn: with a tiny threshold the first can feed the second
					if (s < -mate_thr)
						s += ply;
					if (s > mate_thr)
						s -= ply;
					s = clamp_score(s);
					case (kind_tab[slot])
						BOUND_EXACT: begin
							hit   = 1'b1;
							value = s;
						end
						BOUND_UPPER: begin
							if (s <= longint'($signed(w.alpha))) begin
								hit   = 1'b1;
								value = longint'($signed(w.alpha));
							end
						end
						BOUND_LOWER: begin
							if (s >= longint'($signed(w.beta))) begin
								hit   = 1'b1;
								value = longint'($signed(w.beta));
							end
						end
						default: ;
					endcase
				end
			end
			REQ_STORE: begin
				s = longint'($signed(w.score));
				if (s > mate_thr)
					s += ply;
				else if (s < -mate_thr)
					s -= ply;
				key_tab[slot]   = w.hash;
				depth_tab[slot] = w.depth;
				score_tab[slot] = clamp_score(s);
				kind_tab[slot]  = w.kind;
			end
			REQ_CLEAR: wipe_table();
			default: ;
		endcase
		rsp.found = hit;
		rsp.value = OUT_DATA_W'(value);
		return rsp;
	endfunction

	function automatic void flag_mismatch(input string what, input longint want,
		input longint seen);
		if (errors < 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t got;
		response_t want;
		if (!arst_n) begin
			wipe_table();
			mate_thr = longint'(MATE_THR_RST);
			expected_q.delete();
			errors = 0;
			fail_count <= '0;
			pending <= '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == MATE_THR_ADDR)
				mate_thr = longint'(pwdata[MT_W-1:0]);
			// retire before predicting: a word leaving belongs to an older request
			if (m_tvalid && m_tready) begin
				got = '{found: m_tuser, value: m_tdata};
				if (expected_q.size() == 0) begin
					flag_mismatch("unrequested word, value", 0,
						longint'($signed(got.value)));
				end else begin
					want = expected_q.pop_front();
					if (got.found != want.found)
						flag_mismatch("found", want.found, got.found);
					if (got.value != want.value)
						flag_mismatch("result_value", longint'($signed(want.value)),
							longint'($signed(got.value)));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_request(request_t'(s_tdata), req_t'(s_tuser)));
			fail_count <= errors;
			pending <= expected_q.size();
		end
	end

endmodule

FILE: sim/tb_transposition_table_probe_store.sv
`timescale 1ns / 1ps
module tb_transposition_table_probe_store;
	import ttps_pkg::*;

	// config address of mate_threshold, and the bound kind the table has no meaning for
	localparam logic [PADDR_W-1:0] MATE_THR_ADDR = PADDR_W'(4 * REG_MATE_THR);
	localparam logic [KIND_W-1:0]  BOUND_BAD     = 2'd3;
	localparam int                 POOL          = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// {ply, window_high, window_low, bound_kind, entry_score, search_depth, hash}
	logic [IN_DATA_W-1:0]  s_tdata;
	// [1:0] req_type
	logic [REQ_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [15:0] result_value
	logic [OUT_DATA_W-1:0] m_tdata;
	// [0] found
	logic                  m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic [31:0]           fail_count;
	logic [31:0]           pending;

	// stimulus knobs: chance of a sender gap per word (percent) and the no-stall tail
	int                    gap_pct;
	logic                  drain_quiet;
	logic [MT_W-1:0]       mate_thr_now;
	logic [HASH_W-1:0]     hash_pool [POOL];

	transposition_table_probe_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	ttps_response_checker response_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop; it leaves room for a correct run, clears and the post-reset wipe included
	initial begin
		#12_000_000;
		$display("tb_transposition_table_probe_store: errors");
		$finish;
	end

	// result side: random ready bursts, held high once the tail starts
	initial begin
		int n;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (drain_quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				n = $urandom_range(1, 15);
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat (n) @(posedge clk);
			end
		end
	end

	// one request word; valid stays up into the next word unless a gap is rolled
	task automatic send_request(input req_t req, input logic [HASH_W-1:0] hash,
		input logic [DEPTH_W-1:0] depth, input logic [IN_SCORE_W-1:0] score,
		input logic [KIND_W-1:0] kind, input logic [IN_SCORE_W-1:0] wlo,
		input logic [IN_SCORE_W-1:0] whi, input logic [PLY_W-1:0] ply);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {ply, whi, wlo, kind, score, depth, hash};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// sender holds off until every expected word is back (table idle)
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_mate_threshold(input logic [MT_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MATE_THR_ADDR;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mate_thr_now = v;
	endtask

	// scores: plain random, hugging the mate threshold on either side, or the rails
	function automatic logic [IN_SCORE_W-1:0] pick_score();
		int v;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom_range(0, 65535);
		end else if (sel < 8) begin
			v = int'(mate_thr_now) + $urandom_range(0, 260) - 130;
			if ($urandom_range(0, 1) != 0)
				v = -v;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
		end else begin
			v = (sel == 8) ? 32767 : -32768;
		end
		return IN_SCORE_W'(v);
	endfunction

	// mostly stores and probes over a small hash pool so probes actually land on
	// live entries; some random-hash probes, the odd clear and unknown request
	task automatic send_random_request();
		int                    r;
		logic [HASH_W-1:0]     h;
		logic [DEPTH_W-1:0]    d;
		logic [IN_SCORE_W-1:0] sc;
		logic [KIND_W-1:0]     k;
		logic [IN_SCORE_W-1:0] wl;
		logic [IN_SCORE_W-1:0] wh;
		logic [PLY_W-1:0]      p;
		h  = hash_pool[$urandom_range(0, POOL - 1)];
		if ($urandom_range(0, 9) == 0)
			h = {$urandom, $urandom};
		d  = DEPTH_W'($urandom);
		sc = IN_SCORE_W'($urandom);
		k  = KIND_W'($urandom);
		wl = IN_SCORE_W'($urandom);
		wh = IN_SCORE_W'($urandom);
		p  = PLY_W'($urandom);
		r  = $urandom_range(0, 999);
		if (r < 8) begin
			send_request(REQ_CLEAR, h, d, sc, k, wl, wh, p);
		end else if (r < 40) begin
			send_request(REQ_NONE, h, d, sc, k, wl, wh, p);
		end else if (r < 400) begin
			sc = pick_score();
			if ($urandom_range(0, 9) == 0)
				k = BOUND_BAD;
			else
				k = KIND_W'($urandom_range(0, 2));
			send_request(REQ_STORE, h, d, sc, k, wl, wh, p);
		end else begin
			// shallow asks so stored depth usually covers them
			if ($urandom_range(0, 9) < 7)
				d = DEPTH_W'($urandom_range(0, 40));
			wl = pick_score();
			wh = pick_score();
			send_request(REQ_PROBE, h, d, sc, k, wl, wh, p);
		end
	endtask

	task automatic run_phase(input logic [MT_W-1:0] thr, input int count, input int gap);
		wait_drained();
		write_mate_threshold(thr);
		gap_pct = gap;
		repeat (count) send_random_request();
	endtask

	initial begin
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= REQ_PROBE;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		arst_n      <= 1'b0;
		gap_pct      = 30;
		drain_quiet  = 1'b0;
		mate_thr_now = MATE_THR_RST;

		// pool: random keys, two pairs that each share a slot, the all-zero and all-one keys
		for (int i = 0; i < POOL; i++)
			hash_pool[i] = {$urandom, $urandom};
		hash_pool[1] = {~hash_pool[0][HASH_W-1:IDX_W], hash_pool[0][IDX_W-1:0]};
		hash_pool[2] = '0;
		hash_pool[3] = '1;
		hash_pool[5] = {hash_pool[4][HASH_W-1:IDX_W] ^ 52'h1, hash_pool[4][IDX_W-1:0]};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// the block wipes its table before taking words; send_request just waits

		// --- directed, threshold at reset value ---
		// wiped slot reads key 0 depth 0 score 0 exact: hit at depth 0, miss deeper
		send_request(REQ_PROBE, '0, 7'd0, '0, BOUND_EXACT, '0, '0, 7'd0);
		send_request(REQ_PROBE, '0, 7'd1, '0, BOUND_EXACT, '0, '0, 7'd0);
		// max mate score pushed past the rail by ply, saturates
		send_request(REQ_STORE, '1, 7'd127, 16'h7fff, BOUND_EXACT, '0, '0, 7'd127);
		send_request(REQ_PROBE, '1, 7'd127, '0, BOUND_EXACT, '0, '0, 7'd127);
		send_request(REQ_PROBE, '1, 7'd0, '0, BOUND_EXACT, '0, '0, 7'd0);
		// same slot, other key
		send_request(REQ_PROBE, 64'h8000_0000_0000_0fff, 7'd0, '0, BOUND_EXACT,
			'0, '0, 7'd0);
		// upper bound at the negative rail
		send_request(REQ_STORE, 64'h0123_4567_89ab_cdef, 7'd10, 16'h8000, BOUND_UPPER,
			'0, '0, 7'd127);
		send_request(REQ_PROBE, 64'h0123_4567_89ab_cdef, 7'd10, '0, BOUND_EXACT,
			16'h7fff, '0, 7'd0);
		send_request(REQ_PROBE, 64'h0123_4567_89ab_cdef, 7'd11, '0, BOUND_EXACT,
			16'h7fff, '0, 7'd0);
		send_request(REQ_PROBE, 64'h0123_4567_89ab_cdef, 7'd10, '0, BOUND_EXACT,
			16'h8000, '0, 7'd127);
		// lower bound: beta below score hits, above misses
		send_request(REQ_STORE, 64'hfedc_ba98_7654_3210, 7'd5, 16'd100, BOUND_LOWER,
			'0, '0, 7'd3);
		send_request(REQ_PROBE, 64'hfedc_ba98_7654_3210, 7'd5, '0, BOUND_EXACT,
			'0, 16'd50, 7'd3);
		send_request(REQ_PROBE, 64'hfedc_ba98_7654_3210, 7'd5, '0, BOUND_EXACT,
			'0, 16'd200, 7'd3);
		// bogus bound kind is kept, probe misses
		send_request(REQ_STORE, 64'h5555_aaaa_5555_aaaa, 7'd9, '0, BOUND_BAD, '0, '0, 7'd0);
		send_request(REQ_PROBE, 64'h5555_aaaa_5555_aaaa, 7'd0, '0, BOUND_EXACT,
			'0, '0, 7'd0);
		send_request(REQ_NONE, {$urandom, $urandom}, DEPTH_W'($urandom),
			IN_SCORE_W'($urandom), KIND_W'($urandom), IN_SCORE_W'($urandom),
			IN_SCORE_W'($urandom), PLY_W'($urandom));
		// clear, then the wiped-slot behavior again
		send_request(REQ_CLEAR, '0, '0, '0, BOUND_EXACT, '0, '0, '0);
		send_request(REQ_PROBE, '1, 7'd0, '0, BOUND_EXACT, '0, '0, 7'd0);
		send_request(REQ_PROBE, '0, 7'd0, '0, BOUND_EXACT, '0, '0, 7'd0);

		// --- threshold 0: every nonzero score is a mate score ---
		wait_drained();
		write_mate_threshold('0);
		send_request(REQ_STORE, 64'h0f0f_f0f0_0f0f_f0f0, 7'd20, 16'd1, BOUND_EXACT,
			'0, '0, 7'd5);
		send_request(REQ_PROBE, 64'h0f0f_f0f0_0f0f_f0f0, 7'd20, '0, BOUND_EXACT,
			'0, '0, 7'd10);
		// negative side: ply lift crosses zero and gets pulled back
		send_request(REQ_STORE, 64'h0f0f_f0f0_0f0f_f0f0, 7'd20, 16'hffff, BOUND_EXACT,
			'0, '0, 7'd5);
		send_request(REQ_PROBE, 64'h0f0f_f0f0_0f0f_f0f0, 7'd20, '0, BOUND_EXACT,
			'0, '0, 7'd10);

		// --- threshold at max: only the negative rail is a mate score ---
		wait_drained();
		write_mate_threshold(15'h7fff);
		send_request(REQ_STORE, 64'h3c3c_3c3c_c3c3_c3c3, 7'd1, 16'h8000, BOUND_EXACT,
			'0, '0, 7'd5);
		send_request(REQ_PROBE, 64'h3c3c_3c3c_c3c3_c3c3, 7'd1, '0, BOUND_EXACT,
			'0, '0, 7'd3);

		// --- random phases over several thresholds, sender held off between them ---
		run_phase(MATE_THR_RST, 220, 30);
		run_phase('0, 220, 50);
		run_phase(15'h7fff, 220, 15);
		run_phase(MT_W'($urandom_range(0, 32767)), 220, 30);
		run_phase(MT_W'($urandom_range(1, 300)), 220, 0);
		// tail: no idling on either side
		drain_quiet = 1'b1;
		run_phase(MATE_THR_RST, 180, 0);

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_transposition_table_probe_store: clean");
		else
			$display("tb_transposition_table_probe_store: errors");
		$finish;
	end

endmodule
